// ===== design/mfbr_pkg.sv =====
// ----------------------------------------------------------------------------
// mfbr_pkg
// Shared constants, command codes and control types of the msb-first bit reader.
// ----------------------------------------------------------------------------
`default_nettype none

package mfbr_pkg;

    localparam int BUFFER_BYTES = 256;
    localparam int ADDR_W       = $clog2(BUFFER_BYTES);
    localparam int LEN_W        = ADDR_W + 1;
    localparam int OFF_W        = $clog2(BUFFER_BYTES * 8) + 1;
    localparam int CNT_W        = 12;
    localparam int SUM_W        = ((OFF_W > CNT_W) ? OFF_W : CNT_W) + 1;
    localparam int BYTE_W       = 8;
    localparam int VAL_W        = 64;
    localparam int WID_W        = $clog2(VAL_W) + 1;
    localparam int SPAN_W       = $clog2(VAL_W / BYTE_W + 1) + 1;
    localparam int ACC_W        = VAL_W + BYTE_W;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_SKIP  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef struct packed {
        logic             clear;
        logic             shift;
        logic [2:0]       trail;
        logic [WID_W-1:0] width;
    } t_gather_ctl;

endpackage

`default_nettype wire

// ===== design/mfbr_store.sv =====
// ----------------------------------------------------------------------------
// mfbr_store
// Byte memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbr_store (
    input  wire logic                        i_clk,
    input  wire logic                        i_wr_en,
    input  wire logic [mfbr_pkg::ADDR_W-1:0] i_wr_addr,
    input  wire logic [mfbr_pkg::BYTE_W-1:0] i_wr_data,
    input  wire logic                        i_rd_en,
    input  wire logic [mfbr_pkg::ADDR_W-1:0] i_rd_addr,
    output logic      [mfbr_pkg::BYTE_W-1:0] o_rd_data
);

    logic [mfbr_pkg::BYTE_W-1:0] r_mem [mfbr_pkg::BUFFER_BYTES];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/mfbr_gather.sv =====
// ----------------------------------------------------------------------------
// mfbr_gather
// Collects fetched bytes into a shift register and aligns the read field.
// ----------------------------------------------------------------------------
`default_nettype none

module mfbr_gather (
    input  wire logic                        i_clk,
    input  wire mfbr_pkg::t_gather_ctl       i_ctl,
    input  wire logic [mfbr_pkg::BYTE_W-1:0] i_byte,
    output logic      [mfbr_pkg::VAL_W-1:0]  o_value
);

    logic [mfbr_pkg::ACC_W-1:0] r_acc;
    logic [mfbr_pkg::ACC_W-1:0] w_shifted;
    logic [mfbr_pkg::VAL_W-1:0] w_mask;

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_acc <= '0;
        end else if (i_ctl.shift) begin
            r_acc <= {r_acc[mfbr_pkg::ACC_W-mfbr_pkg::BYTE_W-1:0], i_byte};
        end
    end

    // drop the unread tail of the last byte, keep width bits
    always_comb begin
        w_shifted = r_acc >> i_ctl.trail;
        w_mask    = ~({mfbr_pkg::VAL_W{1'b1}} << i_ctl.width);
        o_value   = w_shifted[mfbr_pkg::VAL_W-1:0] & w_mask;
    end

endmodule

`default_nettype wire

// ===== design/msb_first_bit_reader_unit.sv =====
// ----------------------------------------------------------------------------
// msb_first_bit_reader_unit
// Byte buffer with msb-first field reads, skips, loads and clear.
// ----------------------------------------------------------------------------
// One command word is taken at a time and gives one result word. Load, skip,
// clear and rejected commands go from execute straight to output. A read whose
// field touches k stored bytes (1 to 9) stays in fetch while they are read,
// then passes land and pack, since the bytes come out of the byte memory's one
// read port, one per cycle. A finished result sits in the output register, so
// the next command word can be taken while it waits. The byte memory comes out
// of reset with unknown contents and needs no clearing pass.
`default_nettype none

module msb_first_bit_reader_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [1:0]                   i_command,
    input  wire logic [mfbr_pkg::BYTE_W-1:0]  i_load_byte,
    input  wire logic [mfbr_pkg::CNT_W-1:0]   i_bit_count,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [mfbr_pkg::VAL_W-1:0]   o_field_value,
    output logic                              o_ok
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_LAND,
        S_PACK,
        S_OUT
    } t_state;

    t_state                        r_state;
    mfbr_pkg::t_cmd                r_cmd;
    logic [mfbr_pkg::BYTE_W-1:0]   r_byte;
    logic [mfbr_pkg::CNT_W-1:0]    r_count;
    logic [mfbr_pkg::LEN_W-1:0]    r_length;
    logic [mfbr_pkg::OFF_W-1:0]    r_offset;
    logic [mfbr_pkg::ADDR_W-1:0]   r_addr;
    logic [mfbr_pkg::SPAN_W-1:0]   r_left;
    logic [2:0]                    r_trail;
    logic [mfbr_pkg::WID_W-1:0]    r_width;
    logic                          r_rd_vld;
    logic [mfbr_pkg::VAL_W-1:0]    r_res_value;
    logic                          r_res_ok;

    logic [mfbr_pkg::SUM_W-1:0]    w_end;
    logic [mfbr_pkg::SUM_W-1:0]    w_last;
    logic [mfbr_pkg::SUM_W-1:0]    w_limit;
    logic [mfbr_pkg::SUM_W-1:0]    w_span;
    logic                          w_fits;
    logic                          w_count_ok;
    logic                          w_has_room;
    logic                          w_wr_en;
    logic                          w_rd_en;
    logic [mfbr_pkg::BYTE_W-1:0]   w_rd_data;
    logic [mfbr_pkg::VAL_W-1:0]    w_value;
    mfbr_pkg::t_gather_ctl         w_gctl;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        w_end      = mfbr_pkg::SUM_W'(r_offset) + mfbr_pkg::SUM_W'(r_count);
        w_last     = w_end - mfbr_pkg::SUM_W'(1);
        w_limit    = mfbr_pkg::SUM_W'({r_length, 3'b000});
        w_fits     = (r_offset[mfbr_pkg::OFF_W-1:3] < r_length) && (w_end <= w_limit);
        w_count_ok = (r_count != '0) && (r_count <= mfbr_pkg::CNT_W'(mfbr_pkg::VAL_W));
        w_has_room = (r_length < mfbr_pkg::LEN_W'(mfbr_pkg::BUFFER_BYTES));
        w_span     = (w_last >> 3) - mfbr_pkg::SUM_W'(r_offset[mfbr_pkg::OFF_W-1:3]);
        w_wr_en    = (r_state == S_EXEC) && (r_cmd == mfbr_pkg::CMD_LOAD) && w_has_room;
        w_rd_en    = (r_state == S_FETCH);
        w_gctl.clear = (r_state == S_EXEC);
        w_gctl.shift = r_rd_vld;
        w_gctl.trail = r_trail;
        w_gctl.width = r_width;
    end

    mfbr_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_length[mfbr_pkg::ADDR_W-1:0]),
        .i_wr_data (r_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_addr),
        .o_rd_data (w_rd_data)
    );

    mfbr_gather u_gather (
        .i_clk   (i_clk),
        .i_ctl   (w_gctl),
        .i_byte  (w_rd_data),
        .o_value (w_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_length <= '0;
            r_offset <= '0;
            r_rd_vld <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_rd_vld <= w_rd_en;
            if (o_valid && i_ready && (r_state != S_OUT)) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd   <= mfbr_pkg::t_cmd'(i_command);
                        r_byte  <= i_load_byte;
                        r_count <= i_bit_count;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_value <= '0;
                    r_res_ok    <= 1'b0;
                    r_state     <= S_OUT;
                    unique case (r_cmd)
                        mfbr_pkg::CMD_LOAD: begin
                            if (w_has_room) begin
                                r_length <= r_length + mfbr_pkg::LEN_W'(1);
                                r_res_ok <= 1'b1;
                            end
                        end
                        mfbr_pkg::CMD_READ: begin
                            if (w_count_ok && w_fits) begin
                                r_addr   <= r_offset[mfbr_pkg::ADDR_W+2:3];
                                r_left   <= w_span[mfbr_pkg::SPAN_W-1:0];
                                r_trail  <= 3'(3'd0 - w_end[2:0]);
                                r_width  <= r_count[mfbr_pkg::WID_W-1:0];
                                r_offset <= w_end[mfbr_pkg::OFF_W-1:0];
                                r_state  <= S_FETCH;
                            end
                        end
                        mfbr_pkg::CMD_SKIP: begin
                            if (w_fits) begin
                                r_offset <= w_end[mfbr_pkg::OFF_W-1:0];
                                r_res_ok <= 1'b1;
                            end
                        end
                        mfbr_pkg::CMD_CLEAR: begin
                            r_length <= '0;
                            r_offset <= '0;
                            r_res_ok <= 1'b1;
                        end
                        default: begin
                            r_res_ok <= 1'b0;
                        end
                    endcase
                end
                S_FETCH: begin
                    r_addr <= r_addr + mfbr_pkg::ADDR_W'(1);
                    if (r_left == '0) begin
                        r_state <= S_LAND;
                    end else begin
                        r_left <= r_left - mfbr_pkg::SPAN_W'(1);
                    end
                end
                S_LAND: begin
                    r_state <= S_PACK;
                end
                S_PACK: begin
                    r_res_value <= w_value;
                    r_res_ok    <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid       <= 1'b1;
                        o_field_value <= r_res_value;
                        o_ok          <= r_res_ok;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_length <= mfbr_pkg::LEN_W'(mfbr_pkg::BUFFER_BYTES))
        else $error("loaded length beyond buffer size");

    a_offset_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mfbr_pkg::SUM_W'(r_offset) <= mfbr_pkg::SUM_W'({r_length, 3'b000}))
        else $error("bit offset beyond loaded data");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_ok) |-> (o_field_value == '0))
        else $error("failed result carries a nonzero field");

    a_span_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_left <= mfbr_pkg::SPAN_W'(mfbr_pkg::VAL_W / 8)))
        else $error("read spans more bytes than a field allows");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_EXEC))
        else $error("accepted word not executed next");
`endif

endmodule

`default_nettype wire
